// ===== src/lfu_cache_policy_top_defines.svh =====
// Assertion helpers for the LFU replacement block.
`ifndef LFU_CACHE_POLICY_TOP_DEFINES_SVH
`define LFU_CACHE_POLICY_TOP_DEFINES_SVH

// Antecedent and consequent in the same cycle
`define LFU_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("lfu_cache_policy: same-cycle check failed");

// Consequent in the cycle after the antecedent
`define LFU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("lfu_cache_policy: next-cycle check failed");

`endif

// ===== src/lfu_pkg.sv =====
package lfu_pkg;

    // Request codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // Configuration port
    localparam int   ADDR_W       = 3;
    localparam logic REG_CAPACITY = 1'b0;   // value of the word-select address bit
    localparam int   CAP_W        = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd3;

    // Request transaction
    typedef struct packed {
        logic        req_type;
        logic [31:0] req_key;
        logic [31:0] req_value;
    } req_t;

    // Result transaction
    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic [15:0] use_count;
        logic        evicted;
        logic [31:0] evicted_key;
    } rsp_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MISS,
        ST_HIT,
        ST_AGE,
        ST_INSERT
    } state_t;

endpackage

// ===== src/lfu_cache_policy_top.sv =====
// Sequence: a hit ends the scan at the matching slot, a get miss ends after the full
// scan, and a put miss runs the key/victim scan, then an age sweep, then the insert.
// Throughput: one transaction at a time; busy stays high until the result strobe, and
// a new start is taken in the strobe cycle. Both scans walk the slot RAM one slot per
// cycle through its single read port. The receiver cannot stall the result.
// Reset clears the valid map and occupancy and sets capacity to 3; no clearing pass.
`include "lfu_cache_policy_top_defines.svh"

module lfu_cache_policy_top #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        start,
    output logic                        busy,
    input  lfu_pkg::req_t               req,
    // result channel
    output logic                        done,
    output lfu_pkg::rsp_t               result,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
        logic [IDX_W-1:0]      age;
    } entry_t;

    localparam int EW = $bits(entry_t);

    // Sequencer and request registers
    lfu_pkg::state_t state_reg, state_next;
    logic                  type_reg, type_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;

    // Scan pipeline: issue stage and compare stage
    logic [IDX_W-1:0] issue_idx_reg, issue_idx_next;
    logic             issue_on_reg, issue_on_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             chk_vld_reg, chk_vld_next;

    // Scan results
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    entry_t                hit_ent_reg, hit_ent_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  vic_found_reg, vic_found_next;
    logic [IDX_W-1:0]      vic_idx_reg, vic_idx_next;
    logic [KEY_BITS-1:0]   vic_key_reg, vic_key_next;
    logic [COUNT_BITS-1:0] vic_cnt_reg, vic_cnt_next;
    logic [IDX_W-1:0]      vic_age_reg, vic_age_next;
    logic                  ev_reg, ev_next;
    logic [IDX_W-1:0]      ins_idx_reg, ins_idx_next;

    // Store state
    logic [ENTRIES-1:0]       valid_reg, valid_next;
    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic [lfu_pkg::CAP_W-1:0] cap_reg;

    // Result
    lfu_pkg::rsp_t rsp_reg, rsp_next;
    logic          done_reg, done_next;

    // RAM port signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [EW-1:0]    ram_rdata;
    entry_t           rd_ent;

    // Compare-unit terms
    logic                  chk_valid;
    logic                  chk_match;
    logic                  vic_better;
    logic                  chk_last;
    logic [CMP_W-1:0]      cap_eff;
    logic                  need_evict;
    logic [COUNT_BITS-1:0] hit_cnt_inc;
    logic [IDX_W-1:0]      age_upd;

    assign rd_ent = ram_rdata;

    lfu_slot_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (EW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (issue_idx_reg),
        .rd_data (ram_rdata)
    );

    // Shared compare unit on the slot under check
    always_comb
    begin
        chk_valid  = valid_reg[chk_idx_reg];
        chk_match  = chk_vld_reg && chk_valid && (rd_ent.key == key_reg);
        chk_last   = chk_vld_reg && (chk_idx_reg == LAST_IDX);
        vic_better = !vic_found_reg || (rd_ent.count < vic_cnt_reg) ||
                     ((rd_ent.count == vic_cnt_reg) && (rd_ent.age < vic_age_reg));
        // evicting a slot newer than this one leaves its rank; insertion ages it by one
        age_upd    = (ev_reg && (rd_ent.age > vic_age_reg)) ? rd_ent.age
                                                             : IDX_W'(rd_ent.age + 1'b1);
        hit_cnt_inc = (hit_ent_reg.count == '1) ? hit_ent_reg.count
                                                : COUNT_BITS'(hit_ent_reg.count + 1'b1);
    end

    // Effective capacity, clamped to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = CMP_W'(cap_reg);
        end
        need_evict = CMP_W'(occ_reg) >= cap_eff;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                if (chk_match)
                begin
                    state_next = lfu_pkg::ST_HIT;
                end
                else if (chk_last)
                begin
                    state_next = lfu_pkg::ST_MISS;
                end
            end
            lfu_pkg::ST_MISS:
            begin
                state_next = (type_reg == lfu_pkg::REQ_PUT) ? lfu_pkg::ST_AGE
                                                            : lfu_pkg::ST_IDLE;
            end
            lfu_pkg::ST_AGE:
            begin
                if (chk_last)
                begin
                    state_next = lfu_pkg::ST_INSERT;
                end
            end
            lfu_pkg::ST_HIT:    state_next = lfu_pkg::ST_IDLE;
            lfu_pkg::ST_INSERT: state_next = lfu_pkg::ST_IDLE;
            default:            state_next = lfu_pkg::ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        type_next       = type_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        issue_idx_next  = issue_idx_reg;
        issue_on_next   = issue_on_reg;
        chk_idx_next    = issue_idx_reg;
        chk_vld_next    = 1'b0;
        hit_idx_next    = hit_idx_reg;
        hit_ent_next    = hit_ent_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_key_next    = vic_key_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_age_next    = vic_age_reg;
        ev_next         = ev_reg;
        ins_idx_next    = ins_idx_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        rsp_next        = rsp_reg;
        done_next       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = hit_ent_reg;
        ram_re          = 1'b0;

        // issue stage runs in both sweeps
        if ((state_reg == lfu_pkg::ST_SCAN) || (state_reg == lfu_pkg::ST_AGE))
        begin
            if (issue_on_reg)
            begin
                ram_re       = 1'b1;
                chk_vld_next = 1'b1;
                if (issue_idx_reg == LAST_IDX)
                begin
                    issue_on_next = 1'b0;
                end
                else
                begin
                    issue_idx_next = IDX_W'(issue_idx_reg + 1'b1);
                end
            end
        end

        case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    type_next       = req.req_type;
                    key_next        = KEY_BITS'(req.req_key);
                    val_next        = VALUE_BITS'(req.req_value);
                    issue_idx_next  = '0;
                    issue_on_next   = 1'b1;
                    free_found_next = 1'b0;
                    vic_found_next  = 1'b0;
                    ev_next         = 1'b0;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                if (chk_vld_reg)
                begin
                    if (chk_match)
                    begin
                        hit_idx_next = chk_idx_reg;
                        hit_ent_next = rd_ent;
                    end
                    if (!chk_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (chk_valid && vic_better)
                    begin
                        vic_found_next = 1'b1;
                        vic_idx_next   = chk_idx_reg;
                        vic_key_next   = rd_ent.key;
                        vic_cnt_next   = rd_ent.count;
                        vic_age_next   = rd_ent.age;
                    end
                end
            end
            lfu_pkg::ST_HIT:
            begin
                ram_we          = 1'b1;
                ram_waddr       = hit_idx_reg;
                ram_wdata       = hit_ent_reg;
                ram_wdata.count = hit_cnt_inc;
                if (type_reg == lfu_pkg::REQ_PUT)
                begin
                    ram_wdata.value = val_reg;
                end
                done_next           = 1'b1;
                rsp_next.hit        = 1'b1;
                rsp_next.read_value = (type_reg == lfu_pkg::REQ_GET) ? 32'(hit_ent_reg.value)
                                                                     : '0;
                rsp_next.use_count  = 16'(hit_cnt_inc);
                rsp_next.evicted    = 1'b0;
                rsp_next.evicted_key = '0;
            end
            lfu_pkg::ST_MISS:
            begin
                if (type_reg == lfu_pkg::REQ_GET)
                begin
                    done_next = 1'b1;
                    rsp_next  = '0;
                end
                else
                begin
                    // prepare the age sweep
                    issue_idx_next = '0;
                    issue_on_next  = 1'b1;
                    if (need_evict && vic_found_reg)
                    begin
                        ev_next                 = 1'b1;
                        valid_next[vic_idx_reg] = 1'b0;
                        occ_next                = OCC_W'(occ_reg - 1'b1);
                        ins_idx_next = (free_found_reg && (free_idx_reg < vic_idx_reg))
                                       ? free_idx_reg : vic_idx_reg;
                    end
                    else
                    begin
                        ins_idx_next = free_idx_reg;
                    end
                end
            end
            lfu_pkg::ST_AGE:
            begin
                if (chk_vld_reg && chk_valid)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = chk_idx_reg;
                    ram_wdata     = rd_ent;
                    ram_wdata.age = age_upd;
                end
            end
            lfu_pkg::ST_INSERT:
            begin
                ram_we                  = 1'b1;
                ram_waddr               = ins_idx_reg;
                ram_wdata.key           = key_reg;
                ram_wdata.value         = val_reg;
                ram_wdata.count         = COUNT_BITS'(1);
                ram_wdata.age           = '0;
                valid_next[ins_idx_reg] = 1'b1;
                occ_next                = OCC_W'(occ_reg + 1'b1);
                done_next               = 1'b1;
                rsp_next.hit            = 1'b0;
                rsp_next.read_value     = '0;
                rsp_next.use_count      = 16'd1;
                rsp_next.evicted        = ev_reg;
                rsp_next.evicted_key    = ev_reg ? 32'(vic_key_reg) : '0;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lfu_pkg::ST_IDLE;
            issue_on_reg <= 1'b0;
            chk_vld_reg  <= 1'b0;
            valid_reg    <= '0;
            occ_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_on_reg <= issue_on_next;
            chk_vld_reg  <= chk_vld_next;
            valid_reg    <= valid_next;
            occ_reg      <= occ_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        type_reg       <= type_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        issue_idx_reg  <= issue_idx_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_ent_reg    <= hit_ent_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        vic_found_reg  <= vic_found_next;
        vic_idx_reg    <= vic_idx_next;
        vic_key_reg    <= vic_key_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_age_reg    <= vic_age_next;
        ev_reg         <= ev_next;
        ins_idx_reg    <= ins_idx_next;
        rsp_reg        <= rsp_next;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lfu_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite &&
                 (paddr[lfu_pkg::ADDR_W-1] == lfu_pkg::REG_CAPACITY))
        begin
            cap_reg <= pwdata[lfu_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[lfu_pkg::ADDR_W-1] == lfu_pkg::REG_CAPACITY) ? 32'(cap_reg) : '0;
    assign pready = 1'b1;

    assign busy   = (state_reg != lfu_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    // Checks
    `LFU_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `LFU_ASSERT_SAME(a_hit_no_evict, clk, rst_n, done, !(result.hit && result.evicted))
    `LFU_ASSERT_NEXT(a_insert_done, clk, rst_n, state_reg == lfu_pkg::ST_INSERT,
        done && !result.hit && (result.use_count == 16'd1))

endmodule

// ===== src/lfu_slot_ram.sv =====
module lfu_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== tb/lfu_cache_policy_top_tb.sv =====
`timescale 1ns / 100ps

module lfu_cache_policy_top_tb;

    localparam int ENTRIES      = 16;
    localparam int POOL_SIZE    = 24;
    localparam int PHASE_ITEMS  = 95;
    localparam int HIT_REPEATS  = 20;
    localparam int IDLE_LIMIT   = 2000;     // cycles with no accepted transaction
    localparam int TAIL_CYCLES  = 2 * ENTRIES + 30;
    localparam int MAX_REPORTS  = 10;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [lfu_pkg::ADDR_W-1:0] CAP_ADDR    = 3'd0;
    localparam logic [lfu_pkg::ADDR_W-1:0] UNUSED_ADDR = 3'd4;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    lfu_pkg::req_t req;
    logic done;
    lfu_pkg::rsp_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [lfu_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // Shadow copy of the store
    bit          shadow_valid [ENTRIES];
    logic [31:0] shadow_key   [ENTRIES];
    logic [31:0] shadow_value [ENTRIES];
    logic [15:0] shadow_count [ENTRIES];
    int unsigned shadow_age   [ENTRIES];
    int unsigned shadow_occupancy;
    logic [lfu_pkg::CAP_W-1:0] shadow_capacity;

    lfu_pkg::rsp_t pending_results [$];
    logic [31:0] key_pool [POOL_SIZE];
    int unsigned n_errors;
    int unsigned idle_cycles;

    lfu_cache_policy_top #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (32),
        .VALUE_BITS (32),
        .COUNT_BITS (16)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Expected outcome of one access; updates the shadow store
    function automatic lfu_pkg::rsp_t predict_access(lfu_pkg::req_t r);
        lfu_pkg::rsp_t o;
        int i;
        int hit_slot;
        int victim;
        int free_slot;
        int unsigned cap;
        int unsigned victim_age;
        o = '0;
        hit_slot = -1;
        victim = -1;
        free_slot = -1;
        cap = shadow_capacity;
        if (cap < 1)
            cap = 1;
        if (cap > ENTRIES)
            cap = ENTRIES;

        for (i = 0; i < ENTRIES; i++)
        begin
            if (shadow_valid[i] && shadow_key[i] == r.req_key)
            begin
                hit_slot = i;
                break;
            end
        end

        if (hit_slot >= 0)
        begin
            if (r.req_type == lfu_pkg::REQ_PUT)
                shadow_value[hit_slot] = r.req_value;
            else
                o.read_value = shadow_value[hit_slot];
            if (shadow_count[hit_slot] != COUNT_MAX)
                shadow_count[hit_slot] = shadow_count[hit_slot] + 16'd1;
            o.hit = 1'b1;
            o.use_count = shadow_count[hit_slot];
            return o;
        end

        if (r.req_type == lfu_pkg::REQ_GET)
            return o;

        // Full: drop the lowest count, newest entry on a tie
        if (shadow_occupancy >= cap)
        begin
            for (i = 0; i < ENTRIES; i++)
            begin
                if (!shadow_valid[i])
                    continue;
                if (victim < 0 || shadow_count[i] < shadow_count[victim] ||
                    (shadow_count[i] == shadow_count[victim] &&
                     shadow_age[i] < shadow_age[victim]))
                    victim = i;
            end
            if (victim >= 0)
            begin
                victim_age = shadow_age[victim];
                o.evicted = 1'b1;
                o.evicted_key = shadow_key[victim];
                shadow_valid[victim] = 1'b0;
                if (shadow_occupancy > 0)
                    shadow_occupancy--;
                for (i = 0; i < ENTRIES; i++)
                    if (shadow_valid[i] && shadow_age[i] > victim_age)
                        shadow_age[i]--;
            end
        end

        for (i = 0; i < ENTRIES; i++)
        begin
            if (!shadow_valid[i])
            begin
                free_slot = i;
                break;
            end
        end
        if (free_slot >= 0)
        begin
            for (i = 0; i < ENTRIES; i++)
                if (shadow_valid[i])
                    shadow_age[i]++;
            shadow_valid[free_slot] = 1'b1;
            shadow_key[free_slot]   = r.req_key;
            shadow_value[free_slot] = r.req_value;
            shadow_count[free_slot] = 16'd1;
            shadow_age[free_slot]   = 0;
            shadow_occupancy++;
        end
        o.use_count = 16'd1;
        return o;
    endfunction

    function automatic lfu_pkg::req_t make_req(logic kind, logic [31:0] key,
                                               logic [31:0] value);
        lfu_pkg::req_t r;
        r.req_type  = kind;
        r.req_key   = key;
        r.req_value = value;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name,
                         exp_val, act_val);
        end
    endtask

    // Drive one request and hold it until the block takes it
    task automatic send_item(lfu_pkg::req_t item);
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_access(item));
    endtask

    // Let every outstanding transaction complete
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Register write followed by a read-back of the capacity register
    task automatic write_register(logic [lfu_pkg::ADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == CAP_ADDR)
            shadow_capacity = data[lfu_pkg::CAP_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CAP_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("capacity read-back", {{(32-lfu_pkg::CAP_W){1'b0}}, shadow_capacity},
                    prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Result checker: the block's strobe cannot be held off
    always @(posedge clk)
    begin
        lfu_pkg::rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: result transaction with nothing expected", $realtime);
            end
            else
            begin
                exp_rsp = pending_results.pop_front();
                check_field("hit", exp_rsp.hit, result.hit);
                check_field("read_value", exp_rsp.read_value, result.read_value);
                check_field("use_count", exp_rsp.use_count, result.use_count);
                check_field("evicted", exp_rsp.evicted, result.evicted);
                check_field("evicted_key", exp_rsp.evicted_key, result.evicted_key);
            end
        end
    end

    // Watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Lookups on an empty store
    task automatic test_empty_lookup();
        send_item(make_req(lfu_pkg::REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(make_req(lfu_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000));
    endtask

    // Repeated hits on one entry raise its count step by step
    task automatic test_repeated_hits();
        int i;
        send_item(make_req(lfu_pkg::REQ_PUT, 32'hA5A5_5A5A, 32'h1234_5678));
        for (i = 0; i < HIT_REPEATS; i++)
            send_item(make_req(lfu_pkg::REQ_GET, 32'hA5A5_5A5A, $urandom));
        send_item(make_req(lfu_pkg::REQ_PUT, 32'hA5A5_5A5A, 32'h8765_4321));
    endtask

    // All-zero and all-one keys and values, updates and an eviction at reset capacity
    task automatic test_field_extremes();
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(make_req(lfu_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_req(lfu_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000));
        send_item(make_req(lfu_pkg::REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_0000, 32'h0000_0000));
        send_item(make_req(lfu_pkg::REQ_GET, 32'h0000_0000, 32'h5555_AAAA));
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h1357_9BDF, 32'hAAAA_5555));
        send_item(make_req(lfu_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000));
    endtask

    // Equal counts: the newest insertion goes first
    task automatic test_tie_break();
        wait_idle();
        write_register(CAP_ADDR, 32'd4);
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_0101, 32'h0000_0001));
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_0202, 32'h0000_0002));
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_0303, 32'h0000_0003));
        send_item(make_req(lfu_pkg::REQ_GET, 32'h0000_0202, 32'h0000_0000));
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_0404, 32'h0000_0004));
    endtask

    // Capacity zero, above the slot count, unknown register, exact maximum
    task automatic test_capacity_limits();
        wait_idle();
        write_register(CAP_ADDR, 32'hFFFF_FFE0);
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_0505, 32'h0000_0005));
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_0606, 32'h0000_0006));
        wait_idle();
        write_register(CAP_ADDR, 32'd31);
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_0707, 32'h0000_0007));
        wait_idle();
        write_register(UNUSED_ADDR, 32'd1);
        write_register(CAP_ADDR, 32'd16);
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_0808, 32'h0000_0008));
    endtask

    // Lowering capacity below occupancy: one out, one in, no shrink
    task automatic test_capacity_shrink();
        int i;
        for (i = 0; i < 8; i++)
            send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_1000 + i, $urandom));
        wait_idle();
        write_register(CAP_ADDR, 32'd2);
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_2000, 32'h0000_0020));
        send_item(make_req(lfu_pkg::REQ_PUT, 32'h0000_2001, 32'h0000_0021));
        send_item(make_req(lfu_pkg::REQ_GET, 32'h0000_1003, 32'h0000_0000));
    endtask

    // Random traffic over a small key pool, bursts and gaps, several capacities
    task automatic test_random_traffic();
        logic [31:0] cap_list [8];
        int phase;
        int i;
        int sent;
        int burst;
        int gap;
        logic [31:0] key;
        logic [31:0] value;
        cap_list = '{32'd1, 32'd16, 32'd0, 32'd31, 32'd2, 32'd8, 32'd0, 32'd0};
        cap_list[6] = $urandom_range(1, 16);
        cap_list[7] = $urandom;
        for (phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            write_register(CAP_ADDR, cap_list[phase]);
            for (i = 0; i < POOL_SIZE; i++)
                key_pool[i] = $urandom;
            key_pool[0] = 32'h0000_0000;
            key_pool[1] = 32'hFFFF_FFFF;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 12);
                for (i = 0; i < burst && sent < PHASE_ITEMS; i++)
                begin
                    // mostly pool keys so hits and evictions happen; some stray keys
                    if ($urandom_range(0, 9) == 0)
                        key = $urandom;
                    else
                        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                    case ($urandom_range(0, 7))
                        0: value = 32'h0000_0000;
                        1: value = 32'hFFFF_FFFF;
                        default: value = $urandom;
                    endcase
                    send_item(make_req($urandom_range(0, 1) ? lfu_pkg::REQ_PUT
                                                            : lfu_pkg::REQ_GET,
                                       key, value));
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        int i;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        req     <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        n_errors = 0;
        for (i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_count[i] = '0;
            shadow_age[i]   = 0;
        end
        shadow_occupancy = 0;
        shadow_capacity  = lfu_pkg::CAP_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lookup();
        test_repeated_hits();
        test_field_extremes();
        test_tie_break();
        test_capacity_limits();
        test_capacity_shrink();
        test_random_traffic();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
